@@ rtl/samr_pkg.sv @@
// Shared constants, payload types and memory request types of the slot allocator.
`default_nettype none

package samr_pkg;

  // Pool and model range
  localparam int unsigned SLOTS      = 2048;
  localparam int unsigned MODELS     = 212;
  localparam int unsigned MODEL_LOW  = 400;
  localparam int unsigned MODEL_HIGH = 611;

  // Occupancy is kept as words of slot bits
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BIT_W      = $clog2(WORD_W);
  localparam int unsigned WORDS      = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int unsigned WIDX_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned SLOT_PAD_W = WIDX_W + BIT_W;
  localparam int unsigned SLOT_W     = $clog2(SLOTS);
  localparam int unsigned MODEL_W    = (MODELS > 1) ? $clog2(MODELS) : 1;
  localparam int unsigned CNT_W      = SLOT_W;
  localparam int unsigned DIST_W     = $clog2(MODELS + 1);

  // Request codes
  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_RSVD   = 2'd3
  } req_type_e;

  // Channel payloads
  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  model;
    logic [15:0] slot_index;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] slot_id;
    logic [7:0]  distinct_models;
  } rsp_t;

  // Occupancy memory access
  typedef struct packed {
    logic              re;
    logic [WIDX_W-1:0] raddr;
    logic              we;
    logic [WIDX_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
  } bm_req_t;

  // Slot-to-model memory access
  typedef struct packed {
    logic               re;
    logic [SLOT_W-1:0]  raddr;
    logic               we;
    logic [SLOT_W-1:0]  waddr;
    logic [MODEL_W-1:0] wdata;
  } sr_req_t;

  // Model count memory access
  typedef struct packed {
    logic               re;
    logic [MODEL_W-1:0] raddr;
    logic               we;
    logic [MODEL_W-1:0] waddr;
    logic [CNT_W-1:0]   wdata;
  } cr_req_t;

endpackage

`default_nettype wire

@@ rtl/slot_allocator_model_refcount_core.sv @@
// Slot allocator with per-model reference counts: sequencer, scan unit and count update.
//
// Usage: one request channel (in_valid_i / in_stall_o / in_req_i) and one response
// channel (out_valid_o / out_stall_i / out_rsp_o). A request is taken when valid is
// high and stall is low; each request gives exactly one response, in order.
// Create scans the occupancy bitmap one 32-slot word per cycle for the lowest free
// slot from 1 upward. An out-of-range model, a reserved type or a slot past the
// pool goes straight to the response step; a query or a delete first reads the
// bitmap, and a delete of a taken slot also updates its model's count.
// One request is in work at a time; in_stall_o is high from acceptance until the
// response is loaded into the output register.
// The response register holds its result while out_stall_i is high; a finished
// request then waits in its final step, and the next request may already have
// been accepted while an earlier response waits.
// Reset empties the pool and clears all counts at once (row and entry valid
// bits), with no clearing pass; the block accepts requests as soon as reset is released.
`default_nettype none

module slot_allocator_model_refcount_core import samr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output rsp_t      out_rsp_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_CHK  = 5'b00100,
    ST_CNT  = 5'b01000,
    ST_RESP = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  req_t                req_q, req_d;
  logic                ok_q, ok_d;
  logic [15:0]         id_q, id_d;
  logic [MODEL_W-1:0]  mid_q, mid_d;
  logic [WIDX_W:0]     rd_word_q, rd_word_d;
  logic                chk_valid_q, chk_valid_d;
  logic [WIDX_W-1:0]   chk_word_q, chk_word_d;
  logic [DIST_W-1:0]   distinct_q, distinct_d;
  logic                out_valid_q, out_valid_d;
  rsp_t                out_q, out_d;

  bm_req_t             bm_req;
  sr_req_t             sr_req;
  cr_req_t             cr_req;
  logic [WORD_W-1:0]   bm_rdata;
  logic [MODEL_W-1:0]  sr_rdata;
  logic [CNT_W-1:0]    cr_rdata;

  logic [9:0]          model_idx;
  logic                model_ok;
  logic                slot_in_range;
  logic [WORD_W-1:0]   scan_word;
  logic                free_found;
  logic [BIT_W-1:0]    free_bit;
  logic [SLOT_PAD_W-1:0] new_slot;
  logic                busy;
  logic                cnt_inc;
  logic [CNT_W-1:0]    cnt_adj;
  logic [8:0]          dist_ext;
  logic                out_free;

  // Mark slot 0 and slots past the pool as taken
  function automatic logic [WORD_W-1:0] busy_mask(input logic [WIDX_W-1:0] w);
    logic [WORD_W-1:0]   m;
    logic [SLOT_PAD_W:0] s;
    for (int b = 0; b < WORD_W; b++) begin
      s    = {1'b0, w, BIT_W'(b)};
      m[b] = (s >= (SLOT_PAD_W + 1)'(SLOTS)) || (s == '0);
    end
    return m;
  endfunction

  // Memories
  samr_bitmap u_bitmap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (bm_req),
    .rdata_o (bm_rdata)
  );

  samr_slot_ram u_slot_ram (
    .clk_i   (clk_i),
    .req_i   (sr_req),
    .rdata_o (sr_rdata)
  );

  samr_count_ram u_count_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (cr_req),
    .rdata_o (cr_rdata)
  );

  // Decode the incoming request
  assign model_idx     = in_req_i.model - 10'(MODEL_LOW);
  assign model_ok      = (in_req_i.model >= 10'(MODEL_LOW)) &&
                         (in_req_i.model <= 10'(MODEL_HIGH)) &&
                         (model_idx < 10'(MODELS));
  assign slot_in_range = in_req_i.slot_index < 16'(SLOTS);

  // Find the lowest free bit of the word under check
  always_comb begin
    scan_word  = bm_rdata | busy_mask(chk_word_q);
    free_found = ~&scan_word;
    free_bit   = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!scan_word[b]) begin
        free_bit = BIT_W'(b);
      end
    end
  end

  assign new_slot = {chk_word_q, free_bit};
  assign busy     = bm_rdata[req_q.slot_index[BIT_W-1:0]];

  // Shared count adder: up for create, down for delete
  assign cnt_inc  = (req_q.req_type == REQ_CREATE);
  assign cnt_adj  = cr_rdata + (cnt_inc ? CNT_W'(1) : {CNT_W{1'b1}});

  assign dist_ext = 9'(distinct_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    ok_d        = ok_q;
    id_d        = id_q;
    mid_d       = mid_q;
    rd_word_d   = rd_word_q;
    chk_valid_d = chk_valid_q;
    chk_word_d  = chk_word_q;
    distinct_d  = distinct_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    bm_req      = '0;
    sr_req      = '0;
    cr_req      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d = in_req_i;
          ok_d  = 1'b0;
          id_d  = in_req_i.slot_index;
          unique case (in_req_i.req_type) inside
            REQ_CREATE: begin
              id_d  = '0;
              mid_d = model_idx[MODEL_W-1:0];
              if (model_ok) begin
                rd_word_d   = '0;
                chk_valid_d = 1'b0;
                state_d     = ST_SCAN;
              end else begin
                state_d = ST_RESP;
              end
            end
            REQ_DELETE, REQ_QUERY: begin
              if (slot_in_range) begin
                bm_req.re    = 1'b1;
                bm_req.raddr = in_req_i.slot_index[SLOT_PAD_W-1:BIT_W];
                sr_req.re    = (in_req_i.req_type == REQ_DELETE);
                sr_req.raddr = in_req_i.slot_index[SLOT_W-1:0];
                state_d      = ST_CHK;
              end else begin
                state_d = ST_RESP;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the next word read while checking the previous one
        if (rd_word_q != (WIDX_W + 1)'(WORDS)) begin
          bm_req.re    = 1'b1;
          bm_req.raddr = rd_word_q[WIDX_W-1:0];
          rd_word_d    = rd_word_q + 1'b1;
        end
        chk_valid_d = (rd_word_q != (WIDX_W + 1)'(WORDS));
        chk_word_d  = rd_word_q[WIDX_W-1:0];
        if (chk_valid_q) begin
          if (free_found) begin
            bm_req.we    = 1'b1;
            bm_req.waddr = chk_word_q;
            bm_req.wdata = bm_rdata | (WORD_W'(1) << free_bit);
            sr_req.we    = 1'b1;
            sr_req.waddr = new_slot[SLOT_W-1:0];
            sr_req.wdata = mid_q;
            cr_req.re    = 1'b1;
            cr_req.raddr = mid_q;
            ok_d         = 1'b1;
            id_d         = 16'(new_slot);
            state_d      = ST_CNT;
          end else if (chk_word_q == WIDX_W'(WORDS - 1)) begin
            state_d = ST_RESP;
          end
        end
      end

      ST_CHK: begin
        if (req_q.req_type == REQ_QUERY) begin
          ok_d    = busy;
          state_d = ST_RESP;
        end else if (busy) begin
          // Free the slot and fetch its model count
          ok_d         = 1'b1;
          bm_req.we    = 1'b1;
          bm_req.waddr = req_q.slot_index[SLOT_PAD_W-1:BIT_W];
          bm_req.wdata = bm_rdata & ~(WORD_W'(1) << req_q.slot_index[BIT_W-1:0]);
          mid_d        = sr_rdata;
          if ({1'b0, sr_rdata} < (MODEL_W + 1)'(MODELS)) begin
            cr_req.re    = 1'b1;
            cr_req.raddr = sr_rdata;
            state_d      = ST_CNT;
          end else begin
            state_d = ST_RESP;
          end
        end else begin
          state_d = ST_RESP;
        end
      end

      ST_CNT: begin
        // Update the count and the number of models in use
        if (cnt_inc || (cr_rdata != '0)) begin
          cr_req.we    = 1'b1;
          cr_req.waddr = mid_q;
          cr_req.wdata = cnt_adj;
        end
        if (cnt_inc && (cr_rdata == '0)) begin
          distinct_d = distinct_q + 1'b1;
        end else if (!cnt_inc && (cr_rdata == CNT_W'(1)) && (distinct_q != '0)) begin
          distinct_d = distinct_q - 1'b1;
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        // Load the response once the output register is free
        if (out_free) begin
          out_d.ok              = ok_q;
          out_d.slot_id         = id_q;
          out_d.distinct_models = dist_ext[8] ? 8'hFF : dist_ext[7:0];
          out_valid_d           = 1'b1;
          state_d               = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chk_valid_q <= 1'b0;
      distinct_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chk_valid_q <= chk_valid_d;
      distinct_q  <= distinct_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    ok_q       <= ok_d;
    id_q       <= id_d;
    mid_q      <= mid_d;
    rd_word_q  <= rd_word_d;
    chk_word_q <= chk_word_d;
    out_q      <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Checks
  a_distinct_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    distinct_q <= DIST_W'(MODELS))
    else $error("distinct model count above model range");

  a_no_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.ok && (out_rsp_o.slot_id == 16'd0)))
    else $error("slot zero reported as taken");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request taken while one is in work");

  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_req_i.req_type == REQ_CREATE) && model_ok)
      |=> (state_q == ST_SCAN) && (rd_word_q == '0) && !chk_valid_q)
    else $error("create scan did not start at the first word");

endmodule

`default_nettype wire

@@ rtl/samr_bitmap.sv @@
// Occupancy bitmap memory, one word of slot bits per row, with row valid bits.
`default_nettype none

module samr_bitmap import samr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bm_req_t           req_i,
  output logic [WORD_W-1:0]      rdata_o
);

  logic [WORD_W-1:0] mem_q [WORDS];
  logic [WORDS-1:0]  row_valid_q;
  logic [WORD_W-1:0] rdata_q;
  logic              rvalid_q;

  // Write and registered read of the word array
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  // Mark written rows; a row never written reads as all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (req_i.we) begin
        row_valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= row_valid_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

@@ rtl/samr_slot_ram.sv @@
// Slot-to-model index memory, registered read.
`default_nettype none

module samr_slot_ram import samr_pkg::*; (
  input  wire logic               clk_i,
  input  wire sr_req_t            req_i,
  output logic [MODEL_W-1:0]      rdata_o
);

  logic [MODEL_W-1:0] mem_q [SLOTS];
  logic [MODEL_W-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/samr_count_ram.sv @@
// Per-model usage count memory with entry valid bits, registered read.
`default_nettype none

module samr_count_ram import samr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cr_req_t           req_i,
  output logic [CNT_W-1:0]       rdata_o
);

  logic [CNT_W-1:0]  mem_q [MODELS];
  logic [MODELS-1:0] ent_valid_q;
  logic [CNT_W-1:0]  rdata_q;
  logic              rvalid_q;

  // Write and registered read of the counts
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  // Track written entries; an unwritten count reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (req_i.we) begin
        ent_valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= ent_valid_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

@@ sim/tb_slot_allocator_model_refcount_core.sv @@
// Self-checking testbench for the slot allocator core with per-model reference counts.
`timescale 1ns / 100ps

module tb_slot_allocator_model_refcount_core;
  import samr_pkg::*;

  // Shadow copy of the slot pool; predicts one response per accepted request
  class slot_pool_tracker;
    bit          busy [SLOTS];
    bit [7:0]    owner [SLOTS];
    int unsigned refs [MODELS];
    int unsigned distinct;
    int unsigned live;
    int unsigned errors;
    rsp_t        rsp_due [$];

    // Apply one accepted request to the pool and queue its response
    function void note_request(req_t r);
      rsp_t        e;
      int unsigned m;
      int unsigned s;
      e.ok      = 1'b0;
      e.slot_id = r.slot_index;
      case (req_type_e'(r.req_type))
        REQ_CREATE: begin
          e.slot_id = '0;
          if (r.model >= MODEL_LOW && r.model <= MODEL_HIGH &&
              r.model - MODEL_LOW < MODELS) begin
            m = r.model - MODEL_LOW;
            // lowest free slot from 1 upward
            s = 1;
            while (s < SLOTS && busy[s]) s++;
            if (s < SLOTS) begin
              busy[s]  = 1'b1;
              owner[s] = m[7:0];
              if (refs[m] == 0) distinct++;
              refs[m]++;
              live++;
              e.ok      = 1'b1;
              e.slot_id = s[15:0];
            end
          end
        end
        REQ_DELETE: begin
          if (r.slot_index < SLOTS && busy[r.slot_index]) begin
            m = owner[r.slot_index];
            if (m < MODELS && refs[m] != 0) begin
              refs[m]--;
              if (refs[m] == 0 && distinct != 0) distinct--;
            end
            busy[r.slot_index] = 1'b0;
            live--;
            e.ok = 1'b1;
          end
        end
        REQ_QUERY: e.ok = (r.slot_index < SLOTS) && busy[r.slot_index];
        default: ;
      endcase
      e.distinct_models = (distinct > 255) ? 8'd255 : distinct[7:0];
      rsp_due.push_back(e);
    endfunction

    // Compare one accepted response with the oldest prediction
    function void check_response(rsp_t got);
      rsp_t e;
      if (rsp_due.size() == 0) begin
        errors++;
        $display("%0t: response with nothing pending: ok=%0b slot_id=%0d distinct=%0d",
                 $time, got.ok, got.slot_id, got.distinct_models);
        return;
      end
      e = rsp_due.pop_front();
      if (got.ok !== e.ok || got.slot_id !== e.slot_id ||
          got.distinct_models !== e.distinct_models) begin
        errors++;
        $display("%0t: mismatch: expected ok=%0b slot_id=%0d distinct=%0d,",
                 $time, e.ok, e.slot_id, e.distinct_models);
        $display("    actual ok=%0b slot_id=%0d distinct=%0d",
                 got.ok, got.slot_id, got.distinct_models);
      end
    endfunction

    // First occupied slot at or after start, wrapping; 0 when the pool is empty
    function int unsigned any_live(int unsigned start);
      int unsigned s;
      for (int unsigned i = 0; i < SLOTS; i++) begin
        s = (start + i) % SLOTS;
        if (busy[s]) return s;
      end
      return 0;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_req;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_rsp;
  bit   calm = 1'b0;
  int unsigned hold_left = 0;

  slot_pool_tracker pool = new;

  slot_allocator_model_refcount_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the response channel at random, sometimes in long runs
  always @(negedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if ($urandom_range(999) < 3) begin
      hold_left = $urandom_range(60, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < 25);
    end
  end

  // Check every accepted response
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) pool.check_response(out_rsp);
  end

  function automatic req_t mk(req_type_e t, int unsigned mdl, int unsigned slot);
    req_t r;
    r.req_type   = t;
    r.model      = mdl[9:0];
    r.slot_index = slot[15:0];
    return r;
  endfunction

  // Mostly well-formed requests against live slots, the rest noise
  function automatic req_t random_req();
    int unsigned roll;
    int unsigned create_pct;
    int unsigned sel;
    req_t        r;
    roll       = $urandom_range(99);
    create_pct = (pool.live > 300) ? 25 : 45;
    r.req_type   = 2'($urandom);
    r.model      = 10'($urandom);
    r.slot_index = 16'($urandom);
    if (roll < 12) return r;
    if (roll < 12 + create_pct) begin
      r.req_type = REQ_CREATE;
      if ($urandom_range(99) < 88) r.model = 10'($urandom_range(MODEL_HIGH, MODEL_LOW));
      return r;
    end
    r.req_type = (roll < 80) ? REQ_DELETE : REQ_QUERY;
    sel = $urandom_range(99);
    if (sel < 75) r.slot_index = 16'(pool.any_live($urandom_range(SLOTS - 1)));
    else if (sel < 90) r.slot_index = 16'($urandom_range(SLOTS + 3));
    return r;
  endfunction

  // Offer one request, with random idle cycles ahead of it, and hold it until taken
  task automatic send_req(req_t r);
    while (!calm && $urandom_range(99) < 30) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    if (!calm && $urandom_range(99) < 3) begin
      repeat ($urandom_range(80, 1)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall !== 1'b0);
    pool.note_request(r);
  endtask

  // Hold off the sender until every predicted response has arrived
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pool.rsp_due.size() != 0) @(posedge clk);
  endtask

  // Grow the pool, then free slots and reuse them
  task automatic fill_pool();
    int unsigned s;
    repeat (40)
      send_req(mk(REQ_CREATE, $urandom_range(MODEL_HIGH, MODEL_LOW), 0));
    send_req(mk(REQ_CREATE, MODEL_LOW, 0));
    send_req(mk(REQ_CREATE, MODEL_HIGH, 0));
    send_req(mk(REQ_QUERY, 0, SLOTS - 1));
    repeat (6) begin
      s = pool.any_live($urandom_range(SLOTS - 1, 1));
      send_req(mk(REQ_DELETE, 0, s));
      send_req(mk(REQ_CREATE, $urandom_range(MODEL_HIGH, MODEL_LOW), 0));
    end
    send_req(mk(REQ_DELETE, 0, SLOTS - 1));
    send_req(mk(REQ_CREATE, MODEL_HIGH, 0));
    send_req(mk(REQ_CREATE, 500, 0));
    // thin the pool again with random deletes
    repeat (20) send_req(mk(REQ_DELETE, 0, pool.any_live($urandom_range(SLOTS - 1))));
  endtask

  // Run limit
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Stimulus
  initial begin
    req_t plan [$];
    in_valid = 1'b0;
    in_req   = '0;
    rst_n    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty pool, out-of-range models, reserved type, slot zero and beyond the pool
    plan.push_back(mk(REQ_QUERY, 0, 0));
    plan.push_back(mk(REQ_DELETE, 0, 1));
    plan.push_back(mk(REQ_CREATE, MODEL_LOW - 1, 0));
    plan.push_back(mk(REQ_CREATE, MODEL_HIGH + 1, 0));
    plan.push_back(mk(REQ_CREATE, 0, 65535));
    plan.push_back(mk(REQ_CREATE, 1023, 0));
    plan.push_back(mk(REQ_CREATE, MODEL_LOW, 0));
    plan.push_back(mk(REQ_CREATE, MODEL_HIGH, 0));
    plan.push_back(mk(REQ_CREATE, MODEL_HIGH, 0));
    plan.push_back(mk(REQ_QUERY, 0, 2));
    plan.push_back(mk(REQ_QUERY, 1023, 0));
    plan.push_back(mk(REQ_DELETE, 0, 0));
    plan.push_back(mk(REQ_DELETE, 0, SLOTS));
    plan.push_back(mk(REQ_QUERY, 0, 65535));
    plan.push_back(mk(REQ_DELETE, 1023, 65535));
    plan.push_back(mk(REQ_RSVD, 1023, 3));
    plan.push_back(mk(REQ_RSVD, 0, 65535));
    plan.push_back(mk(REQ_DELETE, 0, 2));
    plan.push_back(mk(REQ_DELETE, 0, 2));
    plan.push_back(mk(REQ_CREATE, 500, 0));
    plan.push_back(mk(REQ_QUERY, 0, SLOTS - 1));
    plan.push_back(mk(REQ_DELETE, 0, 3));
    plan.push_back(mk(REQ_QUERY, 0, 3));
    foreach (plan[i]) send_req(plan[i]);
    drain();

    // random traffic, with a stretch free of idle cycles on both sides
    for (int i = 0; i < 720; i++) begin
      calm = (i >= 300 && i < 450);
      send_req(random_req());
      if (i == 600) drain();
    end
    calm = 1'b0;
    drain();

    fill_pool();
    drain();
    repeat (80) @(posedge clk);

    if (pool.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
